FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the moving average filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MAVG_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mavg assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MAVG_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mavg assertion failed");

`endif

FILE: rtl/core/mavg_pkg.sv
// Shared constants, types and helpers of the moving average filter.
package mavg_pkg;

  localparam int unsigned WINDOW_MAX = 32;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned LenW       = 6;
  localparam int unsigned PosW       = $clog2(WINDOW_MAX);
  localparam int unsigned SumW       = SampleW + PosW;
  localparam int unsigned CntW       = $clog2(SumW);
  localparam logic [LenW-1:0] LEN_RESET = LenW'(8);

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;    // latch sample, start history read
    logic update;     // update running sum, write history
    logic div_start;  // load divider with |sum|
    logic div_step;   // one quotient bit
    logic load_out;   // move signed quotient into output register
  } mavg_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_last;   // current divider step is the final one
  } mavg_status_t;

  // Clamp a written window length into 1..WINDOW_MAX.
  function automatic logic [LenW-1:0] len_clamp(logic [LenW-1:0] v);
    logic [LenW-1:0] r;
    r = v;
    if (v == '0) begin
      r = LenW'(1);
    end else if (v > LenW'(WINDOW_MAX)) begin
      r = LenW'(WINDOW_MAX);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/mavg_if.sv
// Valid/ready stream interfaces for the sample input and the average output.
interface mavg_sample_if
  import mavg_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mavg_average_if
  import mavg_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

FILE: rtl/core/mavg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mavg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/mavg_ctrl.sv
// Controller state machine: sequences read, sum update, division and output.
module mavg_ctrl
  import mavg_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output mavg_cmd_t    cmd_o,
  input  mavg_status_t status_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_UPD   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_START;
      end
      ST_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/mavg_datapath.sv
// Datapath: history memory, running sum, restoring divider and output register.
module mavg_datapath
  import mavg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [LenW-1:0]           cfg_wdata_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  mavg_cmd_t                 cmd_i,
  output mavg_status_t              status_o,
  output logic signed [SampleW-1:0] average_o
);

  logic [LenW-1:0]           len_q;
  logic [PosW-1:0]           pos_q;
  logic [LenW-1:0]           fill_q;
  logic signed [SumW-1:0]    sum_q;
  logic signed [SampleW-1:0] sample_q;
  logic                      old_valid_q;
  logic [SampleW-1:0]        ram_rdata;
  logic signed [SampleW-1:0] old_s;
  logic [PosW-1:0]           old_pos;
  logic [SumW-1:0]           sum_mag;
  logic                      neg_q;
  logic [LenW-1:0]           rem_q;
  logic [SumW-1:0]           quo_q;
  logic [CntW-1:0]           cnt_q;
  logic [LenW:0]             trial;
  logic [SampleW-1:0]        mag;
  logic signed [SampleW-1:0] average_q;

  // Oldest sample in the window sits len slots behind the write slot.
  assign old_pos = pos_q - len_q[PosW-1:0];

  mavg_ram #(
    .Width(SampleW),
    .Depth(WINDOW_MAX)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (cmd_i.update),
    .waddr_i(pos_q),
    .wdata_i(sample_q),
    .raddr_i(old_pos),
    .rdata_o(ram_rdata)
  );

  // Slots not yet written since the last clear read as zero.
  assign old_s = old_valid_q ? $signed(ram_rdata) : '0;

  // Window state: cleared on reset and on every length write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_RESET;
      pos_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (cfg_we_i) begin
      len_q  <= len_clamp(cfg_wdata_i);
      pos_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.update) begin
      pos_q <= pos_q + 1'b1;
      if (fill_q != LenW'(WINDOW_MAX)) begin
        fill_q <= fill_q + 1'b1;
      end
      sum_q <= sum_q - SumW'(old_s) + SumW'(sample_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q    <= sample_i;
      old_valid_q <= (fill_q >= len_q);
    end
  end

  // Restoring divider, one quotient bit per step, MSB first.
  assign sum_mag = sum_q[SumW-1] ? (~sum_q + 1'b1) : sum_q;
  assign trial   = {rem_q, quo_q[SumW-1]} - {1'b0, len_q};
  assign status_o.div_last = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= sum_q[SumW-1];
      rem_q <= '0;
      quo_q <= sum_mag;
      cnt_q <= CntW'(SumW - 1);
    end else if (cmd_i.div_step) begin
      if (!trial[LenW]) begin
        rem_q <= trial[LenW-1:0];
        quo_q <= {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[LenW-2:0], quo_q[SumW-1]};
        quo_q <= {quo_q[SumW-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Apply the sign back; the mean always fits the sample width.
  assign mag = quo_q[SampleW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      average_q <= neg_q ? $signed(~mag + 1'b1) : $signed(mag);
    end
  end

  assign average_o = average_q;

endmodule

FILE: rtl/core/moving_average_filter_core.sv
// Top level of the moving average filter: controller plus datapath.
//
//   channel   direction  payload                 handshake
//   sample_i  in         sample  (16b signed)    valid / ready
//   average_o out        average (16b signed)    valid / ready
//   cfg       in         cfg_wdata_i (6b)        cfg_we_i, no wait
//
// The accepting edge captures the sample and starts the history read.
// A result reaches the output register through the sum update, the divider
// load, 21 steps of the restoring divider, then the output load. A new item
// is accepted only in the idle state, which follows that output load.
// The output register lets the next item in while a result waits; a stalled
// output holds the block in its final state until the register frees up.
// Reset (rst_ni low, asynchronous) clears the window and sets length 8.
module moving_average_filter_core
  import mavg_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  mavg_sample_if.sink    sample_i,
  mavg_average_if.source average_o
);

  mavg_cmd_t    cmd;
  mavg_status_t status;

  // Sequence each item through read, update, divide and output load.
  mavg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .out_valid_o(average_o.valid),
    .out_ready_i(average_o.ready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // Hold window state, running sum and divider; length writes clear the window.
  mavg_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sample_i   (sample_i.sample),
    .cmd_i      (cmd),
    .status_o   (status),
    .average_o  (average_o.average)
  );

endmodule

FILE: rtl/core/mavg_checker.sv
// Port-level checker for the moving average filter and its bind.
`include "assert_macros.svh"

module mavg_checker
  import mavg_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [SampleW-1:0] average_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  `MAVG_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(average_i))
  `MAVG_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_ready_i)
  `MAVG_ASSERT_NEXT(a_no_instant_result, in_acc, !$rose(out_valid_i))

endmodule

bind moving_average_filter_core mavg_checker u_mavg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (sample_i.valid),
  .in_ready_i (sample_i.ready),
  .out_valid_i(average_o.valid),
  .out_ready_i(average_o.ready),
  .average_i  (average_o.average)
);

FILE: sim/moving_average_filter_core_test.sv
// Self-checking testbench for the moving average filter core.
module moving_average_filter_core_test;
  import mavg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [SampleW-1:0] sample_t;

  // Receiver behaviors; each one runs for a random number of cycles.
  typedef enum int {
    SINK_OPEN,     // always ready
    SINK_SPARSE,   // random ready, high with a chance of three in four
    SINK_PATTERN,  // fixed on/off cadence, ready in four of every seven
    SINK_COIN      // fair coin every cycle
  } sink_mode_e;

  localparam int unsigned DRAIN_CYCLES = 30;       // settle time after the last average returns
  localparam int unsigned HOLD_CYCLES  = 400;      // long output hold-off
  localparam int unsigned RANDOM_ITEMS = 1340;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned PINNED_RUN   = 40;       // enough to fill the deepest window
  localparam longint      RUN_LIMIT_NS = 20_000_000;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           cfg_we;
  logic [LenW-1:0] cfg_wdata;

  mavg_sample_if  sample_bus ();
  mavg_average_if average_bus ();

  moving_average_filter_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .sample_i    (sample_bus),
    .average_o   (average_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: delay line, running sum, write slot and window length.
  // ---------------------------------------------------------------------------
  sample_t          history_line [WINDOW_MAX];
  int               window_total;
  logic [PosW-1:0]  next_slot;
  int unsigned      window_len;

  sample_t          expected_means [$];
  int unsigned      fail_count = 0;

  // Sender and receiver control.
  bit               sender_bursty = 1'b1;
  int unsigned      burst_left = 0;
  bit               output_held = 1'b0;

  // Empty the window, as reset and every length write do.
  function automatic void clear_window();
    foreach (history_line[i]) history_line[i] = '0;
    window_total = 0;
    next_slot    = '0;
  endfunction

  // Fold one sample into the window and return the mean, truncated toward zero.
  function automatic sample_t predict_mean(input sample_t value);
    logic [PosW-1:0] leaving_slot;
    // The sample leaving the window was written window_len items ago;
    // a full window of WINDOW_MAX wraps back onto the slot being written.
    leaving_slot = next_slot - PosW'(window_len);
    window_total = window_total - int'(history_line[leaving_slot]) + int'(value);
    history_line[next_slot] = value;
    next_slot = next_slot + 1'b1;
    return sample_t'(window_total / int'(window_len));
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 5))
      0:       return sample_t'(32'h7FFF - $urandom_range(0, 15));
      1:       return sample_t'(32'h8000 + $urandom_range(0, 15));
      2:       return sample_t'($urandom_range(0, 200) - 100);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one item per call; when bursty, in bursts of random length with random gaps.
  // Enter and leave on a falling edge; valid stays high between back-to-back
  // items so it is never dropped and raised in one time step.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input sample_t value);
    int unsigned gap;
    if (sender_bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      // Some bursts follow the last one with no gap at all.
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        sample_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= value;
    do @(posedge clk); while (!sample_bus.ready);
    expected_means.push_back(predict_mean(value));
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected average has come back,
  // then let the block settle.
  task automatic drain_filter();
    sample_bus.valid <= 1'b0;
    @(negedge clk);
    while (expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the window length while the block is idle; the write also empties
  // the window, so mirror both in the predictor.
  task automatic write_window_length(input logic [LenW-1:0] value);
    drain_filter();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    if (value == '0) begin
      window_len = 1;
    end else if (value > WINDOW_MAX) begin
      window_len = WINDOW_MAX;
    end else begin
      window_len = value;
    end
    clear_window();
  endtask

  // Hold the output off for a fixed count of cycles, independent of the sender.
  task automatic hold_output(input int unsigned cycles);
    output_held = 1'b1;
    repeat (cycles) @(posedge clk);
    output_held = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: switch between stall behaviors at random intervals.
  // ---------------------------------------------------------------------------
  initial begin : average_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned tick;
    average_bus.ready = 1'b0;
    mode      = SINK_OPEN;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      tick++;
      if (output_held) begin
        average_bus.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:    average_bus.ready <= 1'b1;
          SINK_SPARSE:  average_bus.ready <= ($urandom_range(0, 3) != 0);
          SINK_PATTERN: average_bus.ready <= ((tick % 7) < 4);
          default:      average_bus.ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each accepted average with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : average_check
    sample_t want;
    if (rst_n && average_bus.valid && average_bus.ready) begin
      if (expected_means.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("unexpected average %0d with nothing pending", average_bus.average);
        end
      end else begin
        want = expected_means.pop_front();
        if (average_bus.average !== want) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("average mismatch: expected %0d, got %0d", want, average_bus.average);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Start up at the reset length of 8: the first averages mix in zeros.
  // Drive both extremes and alternating bit patterns.
  task automatic test_startup_window();
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(16'h8000));
    send_sample(sample_t'(16'h0000));
    send_sample(sample_t'(16'hFFFF));
    send_sample(sample_t'(16'h0001));
    send_sample(sample_t'(16'h5555));
    send_sample(sample_t'(16'hAAAA));
  endtask

  // Walk the length register through its edges: one, zero (stored as one),
  // all ones and just above the depth (both stored as the depth), the depth.
  task automatic test_length_edges();
    write_window_length(LenW'(1));
    send_sample(sample_t'(16'h8000));
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(-5));
    write_window_length(LenW'(0));
    send_sample(sample_t'(7));
    send_sample(sample_t'(-7));
    write_window_length(LenW'(63));
    repeat (4) send_sample(sample_t'(16'h8000));
    send_sample(sample_t'(1));
    // Small negative sum over a deep window truncates toward zero, not down.
    write_window_length(LenW'(WINDOW_MAX + 1));
    send_sample(sample_t'(-3));
    send_sample(sample_t'(0));
    write_window_length(LenW'(WINDOW_MAX));
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(-1));
  endtask

  // Stall the output for a long stretch while the sender keeps offering items
  // back to back, so the block fills and pushes back on its input.
  task automatic test_output_backpressure();
    write_window_length(LenW'(5));
    sender_bursty = 1'b0;
    fork
      hold_output(HOLD_CYCLES);
    join_none
    repeat (40) send_sample(random_sample());
    sender_bursty = 1'b1;
  endtask

  // Random phases, each with its own window length. Some phases open with a
  // run of one extreme value long enough to drive the sum to its limit.
  task automatic test_random_traffic();
    int unsigned     sent;
    int unsigned     phase_items;
    bit              pinned;
    sample_t         pinned_value;
    logic [LenW-1:0] len_code;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len_code = '0;
        1:       len_code = LenW'($urandom_range(WINDOW_MAX + 1, 63));
        2:       len_code = LenW'(WINDOW_MAX);
        3:       len_code = LenW'(1);
        default: len_code = LenW'($urandom_range(1, WINDOW_MAX));
      endcase
      write_window_length(len_code);
      phase_items  = $urandom_range(40, 160);
      pinned       = ($urandom_range(0, 4) == 0);
      pinned_value = $urandom_range(0, 1) ? sample_t'(16'h7FFF) : sample_t'(16'h8000);
      for (int unsigned n = 0; n < phase_items; n++) begin
        send_sample((pinned && n < PINNED_RUN) ? pinned_value : random_sample());
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    sample_bus.valid  = 1'b0;
    sample_bus.sample = '0;
    window_len        = LEN_RESET;
    clear_window();

    // Hold reset, then release it on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_startup_window();
    test_length_edges();
    test_output_backpressure();
    test_random_traffic();

    drain_filter();
    if (fail_count == 0) begin
      $display("moving_average_filter_core_test: done, clean");
    end else begin
      $display("moving_average_filter_core_test: done, errors");
    end
    $finish;
  end

  // Stop a hung run well past the slowest correct one.
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("moving_average_filter_core_test: done, errors");
    $finish;
  end

endmodule

FILE: moving_average_filter_core.f
+incdir+rtl/core
rtl/core/mavg_pkg.sv
rtl/core/mavg_if.sv
rtl/core/mavg_ram.sv
rtl/core/mavg_ctrl.sv
rtl/core/mavg_datapath.sv
rtl/core/moving_average_filter_core.sv
rtl/core/mavg_checker.sv
sim/moving_average_filter_core_test.sv
